// ----- hdl/stg_pkg.sv -----
// Shared types and constants of the smoothstep trajectory generator.
package stg_pkg;

  localparam int NumFingersDef = 6;

  localparam int PosW  = 14;
  localparam int TimeW = 18;
  localparam int SpdW  = 9;
  localparam int OpW   = 2;
  localparam int FingW = 3;

  // Divider: a 34-bit dividend covers elapsed << 16.
  localparam int DvdW = 34;
  localparam int CntW = 6;
  localparam int QW   = 16;

  localparam logic [PosW-1:0]  PosMax   = 14'd10000;
  localparam logic [TimeW-1:0] TimeMax  = 18'h3FFFF;
  localparam logic [TimeW:0]   TickStep = 19'd2;
  localparam logic [SpdW-1:0]  SpdMin   = 9'd1;
  localparam logic [SpdW-1:0]  SpdMax   = 9'd270;
  localparam logic [SpdW-1:0]  SpdReset = 9'd90;
  localparam logic [TimeW-1:0] DistMul  = 18'd18;
  // 3.0 in Q16, the constant term of the smoothstep factor (3 - 2t).
  localparam logic [TimeW-1:0] ThreeQ16 = 18'd196608;
  localparam logic [31:0]      RoundHalf = 32'd32768;

  typedef enum logic [OpW-1:0] {
    OpTick = 2'd0,
    OpSet  = 2'd1,
    OpStop = 2'd2,
    OpNop  = 2'd3
  } opcode_e;

  typedef struct packed {
    logic capture;
    logic clear_idx;
    logic next_idx;
    logic eval;
    logic div_start;
    logic dur_write;
    logic mul1;
    logic mul2;
    logic mul3;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic tick_div;
    logic set_div;
    logic is_tick;
    logic last;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

// ----- hdl/stg_if.sv -----
// Valid/ready channel interfaces for input items, results and the speed register.
interface stg_in_if;
  logic                        valid;
  logic                        ready;
  logic [stg_pkg::OpW-1:0]     opcode;
  logic [stg_pkg::FingW-1:0]   finger;
  logic [stg_pkg::PosW-1:0]    target_hundredths;

  modport source (output valid, opcode, finger, target_hundredths, input ready);
  modport sink   (input valid, opcode, finger, target_hundredths, output ready);
endinterface

interface stg_out_if;
  logic                        valid;
  logic                        ready;
  logic [stg_pkg::FingW-1:0]   finger_out;
  logic [stg_pkg::PosW-1:0]    reference_hundredths;
  logic                        moving;
  logic                        last;

  modport source (output valid, finger_out, reference_hundredths, moving, last, input ready);
  modport sink   (input valid, finger_out, reference_hundredths, moving, last, output ready);
endinterface

interface stg_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [stg_pkg::SpdW-1:0]    speed_wdata;

  modport source (output valid, speed_wdata, input ready);
  modport sink   (input valid, speed_wdata, output ready);
endinterface

// ----- hdl/stg_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module stg_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [stg_pkg::DvdW-1:0]    dividend_i,
  input  logic [stg_pkg::TimeW-1:0]   divisor_i,
  output logic [stg_pkg::DvdW-1:0]    quotient_o,
  output logic                        busy_o
);

  logic [stg_pkg::DvdW-1:0]  dvd_q;
  logic [stg_pkg::TimeW-1:0] dsr_q;
  logic [stg_pkg::TimeW-1:0] rem_q;
  logic [stg_pkg::CntW-1:0]  cnt_q;
  logic                      busy_q;

  logic [stg_pkg::TimeW:0]   rem_sh;
  logic [stg_pkg::TimeW:0]   rem_sub;
  logic                      ge;

  assign rem_sh  = {rem_q, dvd_q[stg_pkg::DvdW-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == stg_pkg::CntW'(stg_pkg::DvdW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // The quotient bits shift into the dividend register from the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[stg_pkg::TimeW-1:0] : rem_sh[stg_pkg::TimeW-1:0];
      dvd_q <= {dvd_q[stg_pkg::DvdW-2:0], ge};
    end
  end

  assign quotient_o = dvd_q;
  assign busy_o     = busy_q;

endmodule

// ----- hdl/stg_datapath.sv -----
// Per-finger state, duration and blend arithmetic, and the result register.
module stg_datapath #(
  parameter int NUM_FINGERS = stg_pkg::NumFingersDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  stg_pkg::cmd_t               cmd_i,
  output stg_pkg::status_t            status_o,
  input  logic [stg_pkg::OpW-1:0]     opcode_i,
  input  logic [stg_pkg::FingW-1:0]   finger_i,
  input  logic [stg_pkg::PosW-1:0]    target_i,
  input  logic                        cfg_we_i,
  input  logic [stg_pkg::SpdW-1:0]    cfg_speed_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [stg_pkg::FingW-1:0]   finger_out_o,
  output logic [stg_pkg::PosW-1:0]    reference_o,
  output logic                        moving_o,
  output logic                        last_o
);

  localparam int IdxW = (NUM_FINGERS > 1) ? $clog2(NUM_FINGERS) : 1;
  localparam int PosW = stg_pkg::PosW;
  localparam int TimeW = stg_pkg::TimeW;

  logic [PosW-1:0]  start_q   [NUM_FINGERS];
  logic [PosW-1:0]  target_q  [NUM_FINGERS];
  logic [PosW-1:0]  ref_q     [NUM_FINGERS];
  logic [TimeW-1:0] elapsed_q [NUM_FINGERS];
  logic [TimeW-1:0] dur_q     [NUM_FINGERS];
  logic             moving_q  [NUM_FINGERS];

  logic [IdxW-1:0]          idx_q;
  logic [stg_pkg::OpW-1:0]  op_q;
  logic [stg_pkg::FingW-1:0] fin_q;
  logic [PosW-1:0]          tgt_q;
  logic [stg_pkg::SpdW-1:0] spd_q;

  logic [31:0]      p1_q;
  logic [TimeW-1:0] k_q;
  logic [16:0]      alpha_q;

  logic             out_valid_q;
  logic [stg_pkg::FingW-1:0] out_fin_q;
  logic [PosW-1:0]  out_ref_q;
  logic             out_mov_q;
  logic             out_last_q;

  logic [31:0]      idx_ext;
  logic             is_last;
  logic             sel;
  logic [PosW-1:0]  cur_ref;
  logic [PosW-1:0]  cur_s;
  logic [PosW-1:0]  cur_g;
  logic [TimeW-1:0] cur_dur;
  logic             cur_mov;
  logic [TimeW:0]   e_sum;
  logic [TimeW-1:0] e_w;
  logic [PosW-1:0]  travel;
  logic [TimeW-1:0] travel18;
  logic [stg_pkg::SpdW-1:0] spd_c;
  logic [PosW-1:0]  diff;
  logic [stg_pkg::QW-1:0] t_w;
  logic [stg_pkg::DvdW-1:0] quot;
  logic             div_busy;
  logic             is_tick;
  logic             is_set;
  logic             is_stop;
  logic [stg_pkg::DvdW-1:0] dvd_sel;
  logic [TimeW-1:0] dsr_sel;
  logic [49:0]      prod2;
  logic [31:0]      prod3;
  logic [15:0]      step_raw;
  logic [PosW-1:0]  step;
  logic [PosW-1:0]  blend_ref;
  logic [TimeW-1:0] dur_new;
  logic             out_free;
  logic [PosW-1:0]  tgt_clamp;

  assign idx_ext = 32'(idx_q);
  assign is_last = idx_ext == 32'(NUM_FINGERS - 1);
  assign sel     = 32'(fin_q) == idx_ext;
  assign is_tick = op_q == stg_pkg::OpTick;
  assign is_set  = op_q == stg_pkg::OpSet;
  assign is_stop = op_q == stg_pkg::OpStop;

  assign cur_ref = ref_q[idx_q];
  assign cur_s   = start_q[idx_q];
  assign cur_g   = target_q[idx_q];
  assign cur_dur = dur_q[idx_q];
  assign cur_mov = moving_q[idx_q];

  assign e_sum = {1'b0, elapsed_q[idx_q]} + stg_pkg::TickStep;
  assign e_w   = (e_sum > {1'b0, stg_pkg::TimeMax}) ? stg_pkg::TimeMax : e_sum[TimeW-1:0];

  assign travel   = (tgt_q >= cur_ref) ? tgt_q - cur_ref : cur_ref - tgt_q;
  assign travel18 = TimeW'(travel) * stg_pkg::DistMul;
  assign spd_c  = (spd_q < stg_pkg::SpdMin) ? stg_pkg::SpdMin :
                  (spd_q > stg_pkg::SpdMax) ? stg_pkg::SpdMax : spd_q;

  assign diff = (cur_g >= cur_s) ? cur_g - cur_s : cur_s - cur_g;

  assign dvd_sel = is_tick ? {e_w, {stg_pkg::QW{1'b0}}} : stg_pkg::DvdW'(travel18);
  assign dsr_sel = is_tick ? cur_dur : TimeW'(spd_c);

  stg_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd_sel),
    .divisor_i  (dsr_sel),
    .quotient_o (quot),
    .busy_o     (div_busy)
  );

  assign t_w     = quot[stg_pkg::QW-1:0];
  assign dur_new = (quot[TimeW-1:0] == '0) ? TimeW'(1) : quot[TimeW-1:0];

  assign prod2    = 50'(p1_q) * 50'(k_q);
  assign prod3    = 32'(alpha_q) * 32'(diff) + stg_pkg::RoundHalf;
  assign step_raw = prod3[31:16];
  assign step     = (step_raw > 16'(diff)) ? diff : step_raw[PosW-1:0];
  assign blend_ref = (cur_g >= cur_s) ? cur_s + step : cur_s - step;

  assign tgt_clamp = (target_i > stg_pkg::PosMax) ? stg_pkg::PosMax : target_i;

  // Item register, finger counter and speed register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      op_q  <= stg_pkg::OpNop;
      fin_q <= '0;
      tgt_q <= '0;
      spd_q <= stg_pkg::SpdReset;
    end else begin
      if (cmd_i.capture) begin
        op_q  <= opcode_i;
        fin_q <= finger_i;
        tgt_q <= tgt_clamp;
      end
      if (cmd_i.clear_idx) begin
        idx_q <= '0;
      end else if (cmd_i.next_idx) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cfg_we_i) begin
        spd_q <= cfg_speed_i;
      end
    end
  end

  // Per-finger state updates, all at the current finger.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_FINGERS; i++) begin
        start_q[i]   <= '0;
        target_q[i]  <= '0;
        ref_q[i]     <= '0;
        elapsed_q[i] <= '0;
        dur_q[i]     <= '0;
        moving_q[i]  <= 1'b0;
      end
    end else begin
      if (cmd_i.eval) begin
        if (is_tick && cur_mov) begin
          elapsed_q[idx_q] <= e_w;
          if (e_w >= cur_dur) begin
            ref_q[idx_q]    <= cur_g;
            moving_q[idx_q] <= 1'b0;
          end
        end else if (is_set && sel) begin
          start_q[idx_q]   <= cur_ref;
          target_q[idx_q]  <= tgt_q;
          elapsed_q[idx_q] <= '0;
          dur_q[idx_q]     <= TimeW'(1);
          moving_q[idx_q]  <= travel > PosW'(1);
          if (travel <= PosW'(1)) begin
            ref_q[idx_q] <= tgt_q;
          end
        end else if (is_stop) begin
          start_q[idx_q]   <= cur_ref;
          target_q[idx_q]  <= cur_ref;
          elapsed_q[idx_q] <= '0;
          dur_q[idx_q]     <= '0;
          moving_q[idx_q]  <= 1'b0;
        end
      end
      if (cmd_i.dur_write) begin
        dur_q[idx_q] <= dur_new;
      end
      if (cmd_i.mul3) begin
        ref_q[idx_q] <= blend_ref;
      end
    end
  end

  // Smoothstep: t*t, then times (3 - 2t), then scaled by the distance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      p1_q <= 32'(t_w) * 32'(t_w);
      k_q  <= stg_pkg::ThreeQ16 - {1'b0, t_w, 1'b0};
    end
    if (cmd_i.mul2) begin
      alpha_q <= prod2[48:32];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_fin_q  <= idx_ext[stg_pkg::FingW-1:0];
      out_ref_q  <= cur_ref;
      out_mov_q  <= cur_mov;
      out_last_q <= is_last;
    end
  end

  assign status_o.tick_div = is_tick && cur_mov && (e_w < cur_dur);
  assign status_o.set_div  = is_set && sel && (travel > PosW'(1));
  assign status_o.is_tick  = is_tick;
  assign status_o.last     = is_last;
  assign status_o.div_busy = div_busy;
  assign status_o.out_free = out_free;

  assign out_valid_o  = out_valid_q;
  assign finger_out_o = out_fin_q;
  assign reference_o  = out_ref_q;
  assign moving_o     = out_mov_q;
  assign last_o       = out_last_q;

endmodule

// ----- hdl/stg_ctrl.sv -----
// Sequencer that walks the fingers of one item and steps the datapath.
module stg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  stg_pkg::status_t  status_i,
  output stg_pkg::cmd_t     cmd_o
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SEval = 3'd1;
  localparam logic [2:0] SDiv  = 3'd2;
  localparam logic [2:0] SMul1 = 3'd3;
  localparam logic [2:0] SMul2 = 3'd4;
  localparam logic [2:0] SMul3 = 3'd5;
  localparam logic [2:0] SEmit = 3'd6;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.capture   = 1'b1;
          cmd_o.clear_idx = 1'b1;
          state_d         = SEval;
        end
      end
      SEval: begin
        cmd_o.eval = 1'b1;
        if (status_i.tick_div || status_i.set_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = SDiv;
        end else begin
          state_d = SEmit;
        end
      end
      SDiv: begin
        if (!status_i.div_busy) begin
          if (status_i.is_tick) begin
            state_d = SMul1;
          end else begin
            cmd_o.dur_write = 1'b1;
            state_d         = SEmit;
          end
        end
      end
      SMul1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = SMul2;
      end
      SMul2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = SMul3;
      end
      SMul3: begin
        cmd_o.mul3 = 1'b1;
        state_d    = SEmit;
      end
      SEmit: begin
        // The result register takes this finger once the previous result has left.
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last) begin
            state_d = SIdle;
          end else begin
            cmd_o.next_idx = 1'b1;
            state_d        = SEval;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == SIdle;

endmodule

// ----- hdl/smoothstep_trajectory_generator_unit.sv -----
// Each finger is evaluated after acceptance and then loaded into the result register;
// a moving finger on a tick that has not yet reached its duration also passes the
// shared divider (elapsed/duration) and three multiply stages, the target finger of a
// set-target that must travel only the divider. The next transaction is accepted the
// cycle after the last result is loaded, and each stalled result holds.
// Reset: every finger at position zero, not moving; speed register 90 deg/s.
module smoothstep_trajectory_generator_unit #(
  parameter int NUM_FINGERS = stg_pkg::NumFingersDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  stg_in_if.sink   in_i,
  stg_cfg_if.sink  cfg_i,
  stg_out_if.source out_o
);

  stg_pkg::cmd_t    cmd;
  stg_pkg::status_t status;
  logic             in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  stg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  stg_datapath #(
    .NUM_FINGERS (NUM_FINGERS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .opcode_i     (in_i.opcode),
    .finger_i     (in_i.finger),
    .target_i     (in_i.target_hundredths),
    .cfg_we_i     (cfg_i.valid),
    .cfg_speed_i  (cfg_i.speed_wdata),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .finger_out_o (out_o.finger_out),
    .reference_o  (out_o.reference_hundredths),
    .moving_o     (out_o.moving),
    .last_o       (out_o.last)
  );

endmodule
